FILE: design/plist_pkg.sv
// Shared types and constants for the positional list store.
package plist_pkg;

  localparam int unsigned CAPACITY   = 64;
  localparam int unsigned DATA_WIDTH = 32;

  // Entry address and element count widths.
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream payloads.
  localparam int unsigned FUNC_W   = 4;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FPOS_W   = 6;
  localparam int unsigned COUNT_W  = 7;

  localparam int unsigned IN_BITS   = FUNC_W + POS_W + VAL_W;
  localparam int unsigned IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = STATUS_W + VAL_W + FPOS_W + 1 + COUNT_W + 1;
  localparam int unsigned OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND   = 4'd0,
    FN_INSERT   = 4'd1,
    FN_GET      = 4'd2,
    FN_SET      = 4'd3,
    FN_REMOVE   = 4'd4,
    FN_POP      = 4'd5,
    FN_FIND     = 4'd6,
    FN_CONTAINS = 4'd7,
    FN_LENGTH   = 4'd8,
    FN_CLEAR    = 4'd9
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UP,
    S_RD,
    S_RDW,
    S_DOWN,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

FILE: design/plist_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module plist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: design/positional_list_store.sv
// Positional list store: an ordered list of up to CAPACITY elements in one RAM.
//
// One request is taken at a time and gives one result. Append, set, length,
// clear, unused codes and every request refused with an error status go
// straight from the execute state to the result, as do find and contains on
// an empty list; get reads the entry at the position. Insert moves each later
// entry up through the single RAM port, one entry per cycle, before it writes
// the new value. Remove moves each later entry down the same way, and pop
// reads the entry first and then moves the later ones down. Find and contains
// read the entries from the front, one per cycle, and stop at the first match.
// A new request can be taken in the cycle after the previous result is loaded
// into the output register; that load waits while the output is held off.
module positional_list_store
  import plist_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: func[3:0], position[10:4], value[42:11], zero fill
  input  logic [IN_TDATA-1:0]  s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: status[1:0], read_value[33:2], found_position[39:34], found[40],
  // count[47:41], is_empty[48], zero fill
  output logic [OUT_TDATA-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready
);

  state_e state_q, state_d;

  logic [FUNC_W-1:0]     func_q, func_d;
  logic [POS_W-1:0]      pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CW-1:0]         len_q, len_d;

  logic [AW-1:0] cnt_q, cnt_d;
  logic          issue_q, issue_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;

  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [DATA_WIDTH-1:0] res_rd_q, res_rd_d;
  logic [AW-1:0]         res_fpos_q, res_fpos_d;
  logic                  res_found_q, res_found_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_BITS-1:0]   out_data_q, out_data_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  logic          in_acc, slot_free;
  logic          pos_lt_len, pos_le_len, is_full, more_down;
  logic [AW-1:0] pos_idx, len_idx, last_idx;

  plist_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA'(out_data_q);

  assign pos_lt_len = 32'(pos_q) < 32'(len_q);
  assign pos_le_len = 32'(pos_q) <= 32'(len_q);
  assign is_full    = 32'(len_q) >= 32'(CAPACITY);
  assign more_down  = (32'(pos_q) + 32'd1) < 32'(len_q);
  assign pos_idx    = AW'(pos_q);
  assign len_idx    = AW'(len_q);
  assign last_idx   = AW'(len_q - CW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (func_q)
          FN_INSERT: begin
            if (pos_le_len && !is_full) begin
              state_d = S_UP;
            end
          end
          FN_GET, FN_POP: begin
            if (pos_lt_len) begin
              state_d = S_RD;
            end
          end
          FN_REMOVE: begin
            if (pos_lt_len) begin
              state_d = S_DOWN;
            end
          end
          FN_FIND, FN_CONTAINS: begin
            if (len_q != '0) begin
              state_d = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_UP: begin
        if (!issue_q && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_RD: state_d = S_RDW;
      S_RDW: begin
        state_d = (func_q == FN_POP) ? S_DOWN : S_DONE;
      end
      S_DOWN: begin
        if (!issue_q && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        if (pend_q && (ram_rdata == val_q)) begin
          state_d = S_DONE;
        end else if (!issue_q && !pend_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    func_d       = func_q;
    pos_d        = pos_q;
    val_d        = val_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    res_status_d = res_status_q;
    res_rd_d     = res_rd_q;
    res_fpos_d   = res_fpos_q;
    res_found_d  = res_found_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    ram_we       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_wdata    = ram_rdata;
    ram_raddr    = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          func_d = s_axis_tdata[FUNC_W-1:0];
          pos_d  = s_axis_tdata[FUNC_W +: POS_W];
          val_d  = DATA_WIDTH'(s_axis_tdata[FUNC_W+POS_W +: VAL_W]);
        end
      end
      S_EXEC: begin
        res_status_d = ST_OK;
        res_rd_d     = '0;
        res_fpos_d   = '0;
        res_found_d  = 1'b0;
        issue_d      = 1'b0;
        case (func_q)
          FN_APPEND: begin
            if (is_full) begin
              res_status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = len_idx;
              ram_wdata = val_q;
              len_d     = len_q + CW'(1);
            end
          end
          FN_INSERT: begin
            if (!pos_le_len) begin
              res_status_d = ST_RANGE;
            end else if (is_full) begin
              res_status_d = ST_FULL;
            end else begin
              // Entries from the end down to the position move up by one.
              issue_d = pos_lt_len;
              cnt_d   = last_idx;
            end
          end
          FN_GET, FN_POP: begin
            if (!pos_lt_len) begin
              res_status_d = ST_RANGE;
            end
          end
          FN_SET: begin
            if (!pos_lt_len) begin
              res_status_d = ST_RANGE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = pos_idx;
              ram_wdata = val_q;
            end
          end
          FN_REMOVE: begin
            if (!pos_lt_len) begin
              res_status_d = ST_RANGE;
            end else begin
              issue_d = more_down;
              cnt_d   = pos_idx + AW'(1);
            end
          end
          FN_FIND, FN_CONTAINS: begin
            issue_d = (len_q != '0);
            cnt_d   = '0;
          end
          FN_CLEAR: len_d = '0;
          default: ;
        endcase
      end
      S_UP: begin
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (issue_q) begin
          pend_d      = 1'b1;
          pend_addr_d = cnt_q + AW'(1);
          if (cnt_q == pos_idx) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q - AW'(1);
          end
        end
        if (!issue_q && !pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = pos_idx;
          ram_wdata = val_q;
          len_d     = len_q + CW'(1);
        end
      end
      S_RD: ram_raddr = pos_idx;
      S_RDW: begin
        res_rd_d = ram_rdata;
        issue_d  = more_down;
        cnt_d    = pos_idx + AW'(1);
      end
      S_DOWN: begin
        // Each later entry moves down by one; each write follows its read in the next cycle.
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (issue_q) begin
          pend_d      = 1'b1;
          pend_addr_d = cnt_q - AW'(1);
          if (cnt_q == last_idx) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
        if (!issue_q && !pend_q) begin
          len_d = len_q - CW'(1);
        end
      end
      S_SCAN: begin
        if (pend_q && (ram_rdata == val_q)) begin
          res_found_d = 1'b1;
          if (func_q == FN_FIND) begin
            res_fpos_d = pend_addr_q;
          end
          issue_d = 1'b0;
        end else if (issue_q) begin
          pend_d      = 1'b1;
          pend_addr_d = cnt_q;
          if (cnt_q == last_idx) begin
            issue_d = 1'b0;
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {(len_q == '0),
                         COUNT_W'(len_q),
                         res_found_q,
                         FPOS_W'(res_fpos_q),
                         VAL_W'(res_rd_q),
                         res_status_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    cnt_q        <= cnt_d;
    pend_addr_q  <= pend_addr_d;
    res_status_q <= res_status_d;
    res_rd_q     <= res_rd_d;
    res_fpos_q   <= res_fpos_d;
    res_found_q  <= res_found_d;
    out_data_q   <= out_data_d;
  end

endmodule

FILE: test/tb.sv
// Self-checking stream testbench for the positional list store.
module tb;
  import plist_pkg::*;

  localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 4'd10;
  localparam logic [FUNC_W-1:0] FN_LAST_CODE    = '1;
  localparam int unsigned       MAX_REPORTS     = 10;
  localparam int unsigned       DRAIN_CYCLES    = 100;
  localparam int unsigned       LONG_HOLD       = 300;

  // Packed from the top down so that status lands in the lowest bits of tdata.
  typedef struct packed {
    logic                is_empty;
    logic [COUNT_W-1:0]  count;
    logic                found;
    logic [FPOS_W-1:0]   found_pos;
    logic [VAL_W-1:0]    read_value;
    logic [STATUS_W-1:0] status;
  } list_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic [IN_TDATA-1:0]  s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [OUT_TDATA-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;

  logic [VAL_W-1:0] list_model[$];
  list_result_t     pending_results[$];
  int unsigned      mismatch_cnt;
  int unsigned      result_idx;
  bit               idle_en;
  int unsigned      sink_hold;
  bit               grow_phase;

  logic [VAL_W-1:0] value_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                       32'h8000_0000, 32'h7FFF_FFFF, 32'hA5A5_A5A5,
                                       32'h5A5A_5A5A, 32'h0000_00FF};

  positional_list_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t apply_list_op(logic [FUNC_W-1:0] f,
                                                 logic [POS_W-1:0] p,
                                                 logic [VAL_W-1:0] v);
    list_result_t r;
    int unsigned  len;
    int unsigned  i;
    r = '0;
    r.status = ST_OK;
    len = list_model.size();
    case (f)
      FN_APPEND: begin
        if (len >= CAPACITY) r.status = ST_FULL;
        else list_model.push_back(v);
      end
      FN_INSERT: begin
        // A bad position is reported ahead of a full list.
        if (p > len) r.status = ST_RANGE;
        else if (len >= CAPACITY) r.status = ST_FULL;
        else list_model.insert(p, v);
      end
      FN_GET: begin
        if (p >= len) r.status = ST_RANGE;
        else r.read_value = list_model[p];
      end
      FN_SET: begin
        if (p >= len) r.status = ST_RANGE;
        else list_model[p] = v;
      end
      FN_REMOVE: begin
        if (p >= len) r.status = ST_RANGE;
        else list_model.delete(p);
      end
      FN_POP: begin
        if (p >= len) r.status = ST_RANGE;
        else begin
          r.read_value = list_model[p];
          list_model.delete(p);
        end
      end
      FN_FIND, FN_CONTAINS: begin
        for (i = 0; i < len && !r.found; i++) begin
          if (list_model[i] == v) begin
            r.found = 1'b1;
            if (f == FN_FIND) r.found_pos = i[FPOS_W-1:0];
          end
        end
      end
      FN_CLEAR: list_model.delete();
      default: ;
    endcase
    r.count    = COUNT_W'(list_model.size());
    r.is_empty = (list_model.size() == 0);
    return r;
  endfunction

  // Offers one request, waits for it to be taken and records its expected result.
  task automatic issue_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
                               logic [VAL_W-1:0] v);
    logic [IN_TDATA-1:0] word;
    word = '0;
    word[FUNC_W-1:0]                    = f;
    word[FUNC_W+POS_W-1:FUNC_W]         = p;
    word[FUNC_W+POS_W+VAL_W-1:FUNC_W+POS_W] = v;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tdata  <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_list_op(f, p, v));
  endtask

  // One request drawn to keep the list moving between empty and full.
  task automatic random_request();
    int unsigned      len;
    int unsigned      r;
    int unsigned      a;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    logic [VAL_W-1:0]  v;
    len = list_model.size();
    if (len == 0) grow_phase = 1'b1;
    else if (len == CAPACITY && $urandom_range(0, 9) == 0) grow_phase = 1'b0;
    else if ($urandom_range(0, 99) == 0) grow_phase = !grow_phase;
    r = $urandom_range(0, 99);
    if (r < 1) f = FN_CLEAR;
    else if (r < 4) f = FN_FIRST_UNUSED + FUNC_W'($urandom_range(0, 5));
    else if (r < 8) f = FN_LENGTH;
    else if (r < 20) f = FN_FIND;
    else if (r < 28) f = FN_CONTAINS;
    else if (r < 38) f = FN_GET;
    else if (r < 46) f = FN_SET;
    else begin
      a = r - 46;
      if (grow_phase) f = (a < 20) ? FN_APPEND : (a < 40) ? FN_INSERT :
                          (a < 47) ? FN_REMOVE : FN_POP;
      else            f = (a < 7) ? FN_APPEND : (a < 14) ? FN_INSERT :
                          (a < 34) ? FN_REMOVE : FN_POP;
    end
    r = $urandom_range(0, 9);
    if (r == 0) p = POS_W'($urandom_range(0, 127));
    else if (r == 1) p = POS_W'(len);
    else p = (len != 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
    if ((f == FN_FIND || f == FN_CONTAINS) && len != 0 && $urandom_range(0, 3) != 0)
      v = list_model[$urandom_range(0, len - 1)];
    else if ($urandom_range(0, 1) == 0) v = value_pool[$urandom_range(0, 7)];
    else v = $urandom();
    issue_request(f, p, v);
  endtask

  // Result sink: random back-pressure, plus a long hold when a test asks for one.
  initial begin
    int unsigned stall_left;
    bit          ready_next;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        ready_next = 1'b0;
        sink_hold--;
      end else if (!idle_en) begin
        ready_next = 1'b1;
      end else if (stall_left > 0) begin
        ready_next = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        ready_next = 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        ready_next = 1'b1;
      end
      m_axis_tready <= ready_next;
    end
  end

  // Compares each delivered result with the oldest expectation.
  initial begin
    list_result_t got;
    list_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = list_result_t'(m_axis_tdata[OUT_BITS-1:0]);
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("result %0d arrived with no request outstanding: %h",
                     result_idx, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $write("result %0d mismatch (exp/got): status %0d/%0d read_value %h/%h ",
                     result_idx, want.status, got.status, want.read_value,
                     got.read_value);
              $display("found_pos %0d/%0d found %0d/%0d count %0d/%0d is_empty %0d/%0d",
                       want.found_pos, got.found_pos, want.found, got.found,
                       want.count, got.count, want.is_empty, got.is_empty);
            end
          end
        end
        result_idx++;
      end
    end
  end

  // Every operation on an empty and a short list, edge values, unused codes.
  task automatic test_basic_ops();
    logic [FUNC_W-1:0] f;
    issue_request(FN_LENGTH, '0, '0);
    issue_request(FN_GET, '0, '0);
    issue_request(FN_POP, '0, '0);
    issue_request(FN_REMOVE, '0, '0);
    issue_request(FN_SET, '0, 32'h1234_5678);
    issue_request(FN_INSERT, 7'd1, 32'h1);
    issue_request(FN_FIND, '0, '0);
    issue_request(FN_CONTAINS, '0, '0);
    issue_request(FN_CLEAR, '0, '0);
    issue_request(FN_INSERT, '0, '1);
    issue_request(FN_APPEND, '1, '0);
    issue_request(FN_INSERT, 7'd1, 32'h1234_5678);
    issue_request(FN_INSERT, 7'd3, 32'h8000_0001);
    issue_request(FN_FIND, '0, '0);
    issue_request(FN_APPEND, '0, '1);
    issue_request(FN_FIND, '0, '1);
    issue_request(FN_CONTAINS, '0, 32'h0000_DEAD);
    issue_request(FN_FIND, '0, 32'h0000_DEAD);
    issue_request(FN_GET, 7'd3, '0);
    issue_request(FN_SET, 7'd2, 32'hA5A5_A5A5);
    issue_request(FN_GET, '1, '0);
    issue_request(FN_POP, '0, '0);
    issue_request(FN_REMOVE, 7'd3, '0);
    for (f = FN_FIRST_UNUSED; f != FN_FIRST_UNUSED - 1'b1; f++) begin
      issue_request(f, '1, '1);
      if (f == FN_LAST_CODE) break;
    end
    issue_request(FN_LENGTH, '0, '0);
    issue_request(FN_CLEAR, '0, '0);
  endtask

  // Fills the list to capacity, probes the full cases and the last slot.
  task automatic test_full_list();
    int unsigned i;
    issue_request(FN_CLEAR, '0, '0);
    for (i = 0; i < CAPACITY; i++)
      issue_request(FN_APPEND, '0, (i % 2 == 0) ? i : $urandom());
    issue_request(FN_APPEND, '0, 32'h1);
    issue_request(FN_INSERT, '0, 32'h2);
    issue_request(FN_INSERT, POS_W'(CAPACITY), 32'h3);
    issue_request(FN_INSERT, POS_W'(CAPACITY + 1), 32'h4);
    issue_request(FN_GET, POS_W'(CAPACITY - 1), '0);
    issue_request(FN_FIND, '0, list_model[CAPACITY-1]);
    issue_request(FN_SET, POS_W'(CAPACITY - 1), '1);
    issue_request(FN_CONTAINS, '0, '1);
    issue_request(FN_REMOVE, '0, '0);
    issue_request(FN_INSERT, '0, '0);
    issue_request(FN_FIND, '0, list_model[CAPACITY-1]);
    issue_request(FN_POP, POS_W'(CAPACITY - 1), '0);
    issue_request(FN_GET, POS_W'(CAPACITY - 1), '0);
    issue_request(FN_LENGTH, '0, '0);
    repeat (8) issue_request(FN_POP, POS_W'($urandom_range(0, list_model.size() - 1)), '0);
    issue_request(FN_CLEAR, '0, '0);
  endtask

  // The sink holds off for a long stretch while requests keep coming.
  task automatic test_output_hold();
    repeat (10) random_request();
    sink_hold = LONG_HOLD;
    repeat (12) random_request();
  endtask

  task automatic test_random_mix();
    repeat (660) random_request();
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    repeat (100) random_request();
  endtask

  initial begin
    mismatch_cnt  = 0;
    result_idx    = 0;
    idle_en       = 1'b1;
    sink_hold     = 0;
    grow_phase    = 1'b1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_ops();
    test_full_list();
    test_output_hold();
    test_random_mix();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("positional_list_store regression: pass");
    end else begin
      $display("positional_list_store regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("positional_list_store regression: fail");
    $finish;
  end

endmodule
